[rtl/core/sha256_byte_stream_hasher_unit_defines.svh]
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher: assertion macros
// Shared concurrent assertion forms, sampled on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SBH_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SBH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/sha256bs_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Round constants, initial hash values and the round functions.
// ----------------------------------------------------------------------------
package sha256bs_pkg;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] r;
        case (idx)
            3'd0:    r = 32'h6a09e667;
            3'd1:    r = 32'hbb67ae85;
            3'd2:    r = 32'h3c6ef372;
            3'd3:    r = 32'ha54ff53a;
            3'd4:    r = 32'h510e527f;
            3'd5:    r = 32'h9b05688c;
            3'd6:    r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] r;
        case (idx)
            6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7;
            default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] big0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] sml0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] sml1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] major(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

[rtl/core/sha256bs_byte_if.sv]
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher: byte channel
// Valid/ready channel carrying one message byte and its flags.
// ----------------------------------------------------------------------------
interface sha256bs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input end_of_message, output ready);
endinterface

[rtl/core/sha256bs_digest_if.sv]
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher: digest channel
// Valid/ready channel carrying one digest word and its position.
// ----------------------------------------------------------------------------
interface sha256bs_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

[rtl/core/sha256_byte_stream_hasher_unit.sv]
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// FIPS 180-4 SHA-256 over a byte stream, one round per cycle.
//
// Each word on byte_in may carry one message byte and may close the message.
// A byte is taken while idle and shifted into a 512-bit block register;
// the 64th byte of a block starts the compression, which runs one round per
// cycle through a single round unit and then folds the working variables into
// the hash in the update state. byte_in.ready is low for the whole compression.
// Closing the message shifts in the 0x80 marker, zero fill and the 64-bit
// big-endian bit length one byte a cycle through the same block register
// (with a second compression when fewer than nine bytes remain in the block),
// compresses, and then presents the eight digest words on digest_out, most
// significant first, last_word on the eighth. The block takes no new byte
// until the eighth digest word has been accepted, and then starts afresh from
// the initial hash values.
// ----------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_unit_defines.svh"

module sha256_byte_stream_hasher_unit
    import sha256bs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    sha256bs_byte_if.sink            byte_in,
    sha256bs_digest_if.source        digest_out
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ROUND  = 3'd1;
    localparam logic [2:0] ST_UPDATE = 3'd2;
    localparam logic [2:0] ST_PAD    = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0]   state_reg, state_next;
    logic [511:0] blk_reg, blk_next;     // byte shift line, then schedule window
    logic [5:0]   fill_reg, fill_next;
    logic [63:0]  bits_reg, bits_next;
    logic [31:0]  h_reg [8];
    logic [31:0]  h_next [8];
    logic [31:0]  v_reg [8];
    logic [31:0]  v_next [8];
    logic [5:0]   rnd_reg, rnd_next;
    logic [2:0]   idx_reg, idx_next;
    logic         pad_reg, pad_next;      // message closed, padding under way
    logic         first_reg, first_next;  // marker byte still to go
    logic         ovf_reg, ovf_next;      // marker landed past the length slot
    logic         final_reg, final_next;  // block in flight is the last one

    logic         byte_acc;
    logic         word_acc;
    logic [31:0]  w_cur;
    logic [31:0]  w_new;
    logic [31:0]  t1;
    logic [31:0]  t2;
    logic [5:0]   len_amt;
    logic [63:0]  len_sh;
    logic [7:0]   pad_byte;

    assign byte_in.ready          = (state_reg == ST_IDLE);
    assign byte_acc               = byte_in.valid && byte_in.ready;
    assign digest_out.valid       = (state_reg == ST_EMIT);
    assign word_acc               = digest_out.valid && digest_out.ready;
    assign digest_out.digest_word = h_reg[0];
    assign digest_out.word_index  = idx_reg;
    assign digest_out.last_word   = (idx_reg == 3'd7);

    // Schedule window: oldest word on top, next word appended at the bottom.
    assign w_cur = blk_reg[511:480];
    assign w_new = w_cur + sml0(blk_reg[479:448]) + blk_reg[223:192]
                 + sml1(blk_reg[63:32]);

    // Shared round unit.
    assign t1 = v_reg[7] + big1(v_reg[4]) + choose(v_reg[4], v_reg[5], v_reg[6])
              + round_k(rnd_reg) + w_cur;
    assign t2 = big0(v_reg[0]) + major(v_reg[0], v_reg[1], v_reg[2]);

    // Length byte for slot 56 + k is bits[63-8k -: 8].
    assign len_amt = {3'd7 - fill_reg[2:0], 3'b000};
    assign len_sh  = bits_reg >> len_amt;

    always_comb
    begin
        if (first_reg)
        begin
            pad_byte = PAD_MARK;
        end
        else if ((fill_reg >= LEN_POS) && !ovf_reg)
        begin
            pad_byte = len_sh[7:0];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        blk_next   = blk_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        pad_next   = pad_reg;
        first_next = first_reg;
        ovf_next   = ovf_reg;
        final_next = final_reg;
        for (int i = 0; i < 8; i++)
        begin
            h_next[i] = h_reg[i];
            v_next[i] = v_reg[i];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (byte_acc)
                begin
                    if (byte_in.byte_present)
                    begin
                        blk_next  = {blk_reg[503:0], byte_in.data_byte};
                        fill_next = fill_reg + 6'd1;
                        bits_next = bits_reg + 64'd8;
                    end
                    if (byte_in.end_of_message)
                    begin
                        pad_next   = 1'b1;
                        first_next = 1'b1;
                    end
                    if (byte_in.byte_present && (fill_reg == LAST_POS))
                    begin
                        state_next = ST_ROUND;
                        rnd_next   = 6'd0;
                        for (int i = 0; i < 8; i++)
                        begin
                            v_next[i] = h_reg[i];
                        end
                    end
                    else if (byte_in.end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end

            ST_ROUND:
            begin
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                blk_next  = {blk_reg[479:0], w_new};
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == LAST_POS)
                begin
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_next[i] = h_reg[i] + v_reg[i];
                end
                if (final_reg)
                begin
                    state_next = ST_EMIT;
                    idx_next   = 3'd0;
                end
                else if (pad_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_PAD:
            begin
                blk_next   = {blk_reg[503:0], pad_byte};
                fill_next  = fill_reg + 6'd1;
                first_next = 1'b0;
                if (fill_reg == LAST_POS)
                begin
                    // block full: the last one only if it carried the length
                    final_next = !first_reg && !ovf_reg;
                    ovf_next   = 1'b0;
                    state_next = ST_ROUND;
                    rnd_next   = 6'd0;
                    for (int i = 0; i < 8; i++)
                    begin
                        v_next[i] = h_reg[i];
                    end
                end
                else if (first_reg && (fill_reg >= LEN_POS))
                begin
                    ovf_next = 1'b1;
                end
            end

            ST_EMIT:
            begin
                if (word_acc)
                begin
                    // rotate so the next word sits at the head
                    for (int i = 0; i < 7; i++)
                    begin
                        h_next[i] = h_reg[i + 1];
                    end
                    h_next[7] = h_reg[0];
                    idx_next  = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            h_next[i] = init_hash(3'(i));
                        end
                        bits_next  = 64'd0;
                        fill_next  = 6'd0;
                        pad_next   = 1'b0;
                        first_next = 1'b0;
                        ovf_next   = 1'b0;
                        final_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= 6'd0;
            bits_reg  <= 64'd0;
            rnd_reg   <= 6'd0;
            idx_reg   <= 3'd0;
            pad_reg   <= 1'b0;
            first_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            final_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= init_hash(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            pad_reg   <= pad_next;
            first_reg <= first_next;
            ovf_reg   <= ovf_next;
            final_reg <= final_next;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        for (int i = 0; i < 8; i++)
        begin
            v_reg[i] <= v_next[i];
        end
    end

    `SBH_ASSERT_NEXT(a_round_ends, (state_reg == ST_ROUND) && (rnd_reg == LAST_POS),
        state_reg == ST_UPDATE, "compression did not close after the last round")
    `SBH_ASSERT_IMPLY(a_pad_pending, state_reg == ST_PAD,
        pad_reg, "padding running without a closed message")
    `SBH_ASSERT_NEXT(a_emit_start, (state_reg == ST_UPDATE) && final_reg,
        digest_out.valid && (idx_reg == 3'd0), "digest did not start at word zero")
    `SBH_ASSERT_NEXT(a_emit_done, word_acc && (idx_reg == 3'd7),
        (state_reg == ST_IDLE) && (bits_reg == 64'd0) && (fill_reg == 6'd0),
        "state not restored after the last digest word")

endmodule
